// ----- hdl/fpda_pkg.sv -----
// Shared types and constants for the fixed-point to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none
package fpda_pkg;

  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned FRAC_MIN       = 1;
  localparam int unsigned FRAC_MAX       = 9;
  localparam int unsigned FRAC_W         = 4;
  localparam int unsigned MAX_CHARS      = 16;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = CFG_IDX_W'(1);

  localparam logic [FRAC_W-1:0] FRAC_BITS_RST   = FRAC_W'(4);
  localparam logic              SIGNED_MODE_RST = 1'b1;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;
  localparam logic [6:0] ASCII_POINT = 7'h2E;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_cmd_e;

endpackage
`default_nettype wire

// ----- hdl/fixed_point_to_decimal_ascii.sv -----
// Top level: fixed-point word to decimal ASCII character stream.
// A request is converted by a bit-serial pass through the digit cell row, then leading
// zero digits are skipped and the sign, integer digits, point and fraction digits follow.
// A new request is accepted only once the last character of the previous one has been
// emitted; output stalls hold the character stream.
// Reset: frac_bits = 4, signed_mode = 1, block idle with no output pending.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_to_decimal_ascii
  import fpda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]               cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]              cfg_data_i,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire  [((VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,  // value
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  output logic [7:0]                         m_axis_tdata_o,  // char_code
  output logic                               m_axis_tlast_o
);

  localparam int unsigned NDIG  = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned BCW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned DCW   = $clog2(NDIG + 1);
  localparam int unsigned CCW   = $clog2(MAX_CHARS);
  localparam int unsigned EXT_W = VALUE_BITS + FRAC_MAX;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_INT   = 3'd4;
  localparam logic [2:0] ST_POINT = 3'd5;
  localparam logic [2:0] ST_FRAC  = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [FRAC_W-1:0]       frac_bits_q;
  logic                    signed_mode_q;
  logic [FRAC_W-1:0]       f_eff;
  logic [FRAC_W-1:0]       f_q, f_d;
  logic                    neg_q, neg_d;
  logic [VALUE_BITS-1:0]   ip_q, ip_d;
  logic [FRAC_MAX-1:0]     fp_q, fp_d;
  logic [BCW-1:0]          bit_cnt_q, bit_cnt_d;
  logic [DCW-1:0]          dig_cnt_q, dig_cnt_d;
  logic [FRAC_W-1:0]       frac_cnt_q, frac_cnt_d;
  logic [CCW-1:0]          char_cnt_q, char_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [6:0]              out_char_q, out_char_d;
  logic                    out_last_q, out_last_d;

  logic [VALUE_BITS-1:0]   value;
  logic [VALUE_BITS-1:0]   mag;
  logic [EXT_W-1:0]        mag_ext;
  logic [FRAC_MAX:0]       fmask_new, fmask_cur;
  logic [FRAC_MAX+3:0]     t10;
  logic [3:0]              frac_digit;
  logic [3:0]              top_digit;
  logic                    adv;
  logic                    emit;
  logic                    nat_last;
  logic [6:0]              emit_char;
  logic [3:0]              emit_digit;
  logic                    digit_emit;
  cell_cmd_e               cell_cmd;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bits_q   <= FRAC_BITS_RST;
      signed_mode_q <= SIGNED_MODE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_FRAC_BITS) begin
        frac_bits_q <= cfg_data_i[FRAC_W-1:0];
      end else if (cfg_index_i == REG_SIGNED_MODE) begin
        signed_mode_q <= cfg_data_i[0];
      end
    end
  end

  always_comb begin
    if (frac_bits_q < FRAC_W'(FRAC_MIN)) begin
      f_eff = FRAC_W'(FRAC_MIN);
    end else if (frac_bits_q > FRAC_W'(FRAC_MAX)) begin
      f_eff = FRAC_W'(FRAC_MAX);
    end else begin
      f_eff = frac_bits_q;
    end
  end

  // input split into magnitude, integer and fraction parts
  assign value     = s_axis_tdata_i[VALUE_BITS-1:0];
  assign neg_d     = signed_mode_q & value[VALUE_BITS-1];
  assign mag       = neg_d ? (~value) + VALUE_BITS'(1) : value;
  assign mag_ext   = {{FRAC_MAX{1'b0}}, mag};
  assign fmask_new = ((FRAC_MAX+1)'(1) << f_eff) - (FRAC_MAX+1)'(1);
  assign fmask_cur = ((FRAC_MAX+1)'(1) << f_q) - (FRAC_MAX+1)'(1);

  // fraction digits: multiply by ten, digit is the overflow above f bits
  assign t10        = ({4'd0, fp_q} << 3) + ({4'd0, fp_q} << 1);
  assign frac_digit = 4'(t10 >> f_q);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign adv             = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d    = state_q;
    f_d        = f_q;
    ip_d       = ip_q;
    fp_d       = fp_q;
    bit_cnt_d  = bit_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    frac_cnt_d = frac_cnt_q;
    cell_cmd   = CELL_HOLD;
    emit       = 1'b0;
    nat_last   = 1'b0;
    emit_char  = ASCII_POINT;
    emit_digit = 4'd0;
    digit_emit = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cell_cmd  = CELL_CLEAR;
          f_d       = f_eff;
          ip_d      = VALUE_BITS'(mag >> f_eff);
          for (int k = 0; k < FRAC_MAX; k++) begin
            fp_d[k] = mag_ext[k] & fmask_new[k];
          end
          bit_cnt_d = BCW'(VALUE_BITS);
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_cmd  = CELL_DABBLE;
        ip_d      = {ip_q[VALUE_BITS-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BCW'(1);
        if (bit_cnt_q == BCW'(1)) begin
          dig_cnt_d = DCW'(NDIG);
          state_d   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt_q > DCW'(1)) begin
          cell_cmd  = CELL_SHIFT;
          dig_cnt_d = dig_cnt_q - DCW'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        if (adv) begin
          emit      = 1'b1;
          emit_char = ASCII_MINUS;
          state_d   = ST_INT;
        end
      end
      ST_INT: begin
        if (adv) begin
          emit       = 1'b1;
          digit_emit = 1'b1;
          emit_digit = top_digit;
          emit_char  = ASCII_ZERO + {3'd0, top_digit};
          cell_cmd   = CELL_SHIFT;
          dig_cnt_d  = dig_cnt_q - DCW'(1);
          if (dig_cnt_q == DCW'(1)) begin
            state_d = ST_POINT;
          end
        end
      end
      ST_POINT: begin
        if (adv) begin
          emit       = 1'b1;
          emit_char  = ASCII_POINT;
          frac_cnt_d = f_q;
          state_d    = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (adv) begin
          emit       = 1'b1;
          digit_emit = 1'b1;
          emit_digit = frac_digit;
          emit_char  = ASCII_ZERO + {3'd0, frac_digit};
          fp_d       = t10[FRAC_MAX-1:0] & fmask_cur[FRAC_MAX-1:0];
          frac_cnt_d = frac_cnt_q - FRAC_W'(1);
          nat_last   = (frac_cnt_q == FRAC_W'(1));
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    char_cnt_d  = char_cnt_q;
    if (state_q == ST_IDLE) begin
      char_cnt_d = CCW'(0);
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_last_d  = nat_last || (char_cnt_q == CCW'(MAX_CHARS - 1));
      char_cnt_d  = char_cnt_q + CCW'(1);
      if (out_last_d) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      frac_cnt_q  <= '0;
      char_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      frac_cnt_q  <= frac_cnt_d;
      char_cnt_q  <= char_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    ip_q       <= ip_d;
    fp_q       <= fp_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (state_q == ST_IDLE) begin
      neg_q <= neg_d;
    end
  end

  fpda_chain #(
    .NDIG (NDIG)
  ) u_chain (
    .clk_i       (clk_i),
    .cmd_i       (cell_cmd),
    .bit_i       (ip_q[VALUE_BITS-1]),
    .top_digit_o (top_digit)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_CONV)
    else $error("accepted request did not start conversion");

  a_conv_no_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> char_cnt_q == CCW'(0) && bit_cnt_q != BCW'(0))
    else $error("conversion state with characters counted or no bits left");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_emit |-> emit_digit <= 4'd9)
    else $error("emitted digit out of decimal range");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SKIP || state_q == ST_INT |-> dig_cnt_q != DCW'(0))
    else $error("integer digit count ran out");

  a_frac_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FRAC |-> frac_cnt_q != FRAC_W'(0))
    else $error("fraction digit count ran out");

endmodule
`default_nettype wire

// ----- hdl/fpda_cell.sv -----
// One BCD digit cell: clear, double-dabble step or digit shift toward the top.
`timescale 1ns / 1ps
`default_nettype none
module fpda_cell
  import fpda_pkg::*;
(
  input  wire             clk_i,
  input  cell_cmd_e       cmd_i,
  input  wire             bit_i,
  input  wire       [3:0] digit_i,
  output logic            carry_o,
  output logic      [3:0] digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o = adj[3];
    case (cmd_i)
      CELL_CLEAR:  digit_d = 4'd0;
      CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule
`default_nettype wire

// ----- hdl/fpda_chain.sv -----
// Row of BCD digit cells; bits enter at the low cell, digits leave at the top cell.
`timescale 1ns / 1ps
`default_nettype none
module fpda_chain
  import fpda_pkg::*;
#(
  parameter int unsigned NDIG = 5
) (
  input  wire             clk_i,
  input  cell_cmd_e       cmd_i,
  input  wire             bit_i,
  output logic      [3:0] top_digit_o
);

  logic [NDIG-1:0]      carry;
  logic [NDIG-1:0][3:0] digit;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_low
      fpda_cell u_cell (
        .clk_i   (clk_i),
        .cmd_i   (cmd_i),
        .bit_i   (bit_i),
        .digit_i (4'd0),
        .carry_o (carry[i]),
        .digit_o (digit[i])
      );
    end else begin : g_mid
      fpda_cell u_cell (
        .clk_i   (clk_i),
        .cmd_i   (cmd_i),
        .bit_i   (carry[i-1]),
        .digit_i (digit[i-1]),
        .carry_o (carry[i]),
        .digit_o (digit[i])
      );
    end
  end

  assign top_digit_o = digit[NDIG-1];

endmodule
`default_nettype wire
